// ----- rtl/core/dkal_pkg.sv -----
// dkal_pkg: shared constants, codes and types of the device key allow list.
// No dependencies; compiled first.
package dkal_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;

  localparam int KIND_W   = 3;
  localparam int KEY_W    = 64;
  localparam int LEN_W    = 8;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FSLOT_W  = 6;
  localparam int LIVE_W   = 7;
  localparam int CMP_W    = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;

  localparam logic [LEN_W-1:0] KEY_BYTES = LEN_W'(8);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 3'd0,
    KIND_DEL   = 3'd1,
    KIND_FIND  = 3'd2,
    KIND_GET   = 3'd3,
    KIND_WIPE  = 3'd4,
    KIND_COUNT = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_BADLEN  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_GET_RD,
    S_GET_DN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  key_length;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [FSLOT_W-1:0] slot;
    logic [KEY_W-1:0]   key;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/core/dkal_in_if.sv -----
// dkal_in_if: request channel (valid/ready plus one request item).
// Depends on dkal_pkg.
interface dkal_in_if import dkal_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key;
  logic [LEN_W-1:0]  key_length;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, kind, key, key_length, slot, input ready);
  modport sink   (input valid, kind, key, key_length, slot, output ready);
endinterface

// ----- rtl/core/dkal_out_if.sv -----
// dkal_out_if: result channel (valid/ready plus one result item).
// Depends on dkal_pkg.
interface dkal_out_if import dkal_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FSLOT_W-1:0]  found_slot;
  logic [KEY_W-1:0]    found_key;
  logic [LIVE_W-1:0]   live_count;

  modport source (output valid, status, found_slot, found_key, live_count, input ready);
  modport sink   (input valid, status, found_slot, found_key, live_count, output ready);
endinterface

// ----- rtl/core/device_key_allow_list.sv -----
// device_key_allow_list: top level; sequencer, key memory, result register.
// Depends on dkal_pkg, dkal_in_if, dkal_out_if, dkal_key_mem, dkal_seq.
//
//   channel  | dir | handshake             | payload
//   in_i     | in  | valid/ready, sink     | kind, key, key_length, slot
//   out_o    | out | valid/ready, source   | status, found_slot, found_key, live_count
//
// Add, delete and find scan live slots 0..count-1, one key memory read per
// cycle into the single comparator; delete then moves the last key into the
// hit slot if it is not the last one. Get reads its slot; wipe and count skip memory.
// Reset clears count and sequencer; the key memory is not cleared since
// live keys always sit in slots 0..count-1.
// A finished result waits in the sequencer while the output register is full and not read.
module device_key_allow_list import dkal_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dkal_in_if.sink     in_i,
  dkal_out_if.source  out_o
);

  in_item_t          in_item;
  res_t              res;
  logic              res_valid;
  logic              res_take;
  logic              in_ready;
  logic [CNT_W-1:0]  count;
  mem_req_t          mem_req;
  logic [KEY_W-1:0]  mem_rdata;

  logic                out_vld_q;
  logic [STATUS_W-1:0] status_q;
  logic [FSLOT_W-1:0]  fslot_q;
  logic [KEY_W-1:0]    fkey_q;
  logic [LIVE_W-1:0]   live_q;

  assign in_item = '{kind: in_i.kind, key: in_i.key, key_length: in_i.key_length,
                     slot: in_i.slot};

  dkal_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_item_i   (in_item),
    .in_ready_o  (in_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .count_o     (count),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  dkal_key_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign res_take = res_valid && (!out_vld_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_take) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      status_q <= res.status;
      fslot_q  <= res.slot;
      fkey_q   <= res.key;
      live_q   <= LIVE_W'(count);
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_vld_q;
  assign out_o.status     = status_q;
  assign out_o.found_slot = fslot_q;
  assign out_o.found_key  = fkey_q;
  assign out_o.live_count = live_q;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("accepted item did not leave idle");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_take && (res.status == ST_FULL)) |-> (count == CNT_W'(TABLE_ENTRIES)))
    else $error("full reported below capacity");

  a_out_from_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(res_take))
    else $error("output valid without a result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (count <= CNT_W'(TABLE_ENTRIES)))
    else $error("live count out of range");
`endif

endmodule

// ----- rtl/core/dkal_key_mem.sv -----
// dkal_key_mem: key store, one write and one registered read port.
// Depends on dkal_pkg.
module dkal_key_mem import dkal_pkg::*; (
  input  logic             clk_i,
  input  mem_req_t         req_i,
  output logic [KEY_W-1:0] rdata_o
);

  logic [KEY_W-1:0] mem [TABLE_ENTRIES];
  logic [KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/dkal_seq.sv -----
// dkal_seq: operation sequencer with the shared 64-bit key comparator.
// Depends on dkal_pkg; drives the key memory port of dkal_key_mem.
module dkal_seq import dkal_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  in_item_t         in_item_i,
  output logic             in_ready_o,
  output logic             res_valid_o,
  output res_t             res_o,
  input  logic             res_take_i,
  output logic [CNT_W-1:0] count_o,
  output mem_req_t         mem_req_o,
  input  logic [KEY_W-1:0] mem_rdata_i
);

  state_e            state_q, state_d;
  kind_e             op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  cidx_q, cidx_d;
  logic [IDX_W-1:0]  hit_q, hit_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  count_q, count_d;
  res_t              res_q, res_d;
  logic              in_fire;
  logic              hit;
  logic [CNT_W-1:0]  last;

  assign in_fire = in_valid_i && (state_q == S_IDLE);
  assign hit     = pend_q && (mem_rdata_i == key_q);
  assign last    = count_q - CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    slot_q <= slot_d;
    idx_q  <= idx_d;
    cidx_q <= cidx_d;
    hit_q  <= hit_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    slot_d    = slot_q;
    idx_d     = idx_q;
    cidx_d    = cidx_q;
    hit_d     = hit_q;
    pend_d    = 1'b0;
    count_d   = count_q;
    res_d     = res_q;
    mem_req_o = '{we: 1'b0, waddr: count_q[IDX_W-1:0], wdata: key_q,
                  raddr: idx_q[IDX_W-1:0]};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_d   = '{status: ST_OK, slot: '0, key: '0};
          state_d = S_RESP;
          key_d   = in_item_i.key;
          slot_d  = in_item_i.slot;
          unique case (in_item_i.kind)
            KIND_ADD, KIND_DEL, KIND_FIND: begin
              op_d = kind_e'(in_item_i.kind);
              if (in_item_i.key_length != KEY_BYTES) begin
                res_d.status = ST_BADLEN;
              end else begin
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            KIND_GET: begin
              if (CMP_W'(in_item_i.slot) < CMP_W'(count_q)) begin
                state_d = S_GET_RD;
              end else begin
                res_d.status = ST_MISSING;
              end
            end
            KIND_WIPE: count_d = '0;
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          state_d   = S_RESP;
          res_d.slot = FSLOT_W'(cidx_q);
          unique case (op_q)
            KIND_ADD: res_d.status = ST_DUP;
            KIND_DEL: begin
              hit_d = cidx_q;
              if (CNT_W'(cidx_q) == last) begin
                count_d = last;
              end else begin
                state_d = S_MOVE_RD;
              end
              res_d.slot = '0;
            end
            default: ;
          endcase
        end else if (idx_q == count_q) begin
          state_d = S_RESP;
          if (op_q == KIND_ADD) begin
            if (count_q == CNT_W'(TABLE_ENTRIES)) begin
              res_d.status = ST_FULL;
            end else begin
              mem_req_o.we = 1'b1;
              count_d      = count_q + CNT_W'(1);
              res_d.slot   = FSLOT_W'(count_q[IDX_W-1:0]);
            end
          end else begin
            res_d.status = ST_MISSING;
          end
        end else begin
          cidx_d = idx_q[IDX_W-1:0];
          idx_d  = idx_q + CNT_W'(1);
          pend_d = 1'b1;
        end
      end

      S_MOVE_RD: begin
        mem_req_o.raddr = last[IDX_W-1:0];
        state_d         = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = hit_q;
        mem_req_o.wdata = mem_rdata_i;
        count_d         = last;
        state_d         = S_RESP;
      end

      S_GET_RD: begin
        mem_req_o.raddr = IDX_W'(slot_q);
        state_d         = S_GET_DN;
      end

      S_GET_DN: begin
        res_d.key = mem_rdata_i;
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;
  assign count_o     = count_q;

endmodule
